>>> hdl/slfr_pkg.sv
// Shared constants, codes and beat structs for the sensor link frame receiver.
// No dependencies; the top level, frame assembler and response matcher import this package.
package slfr_pkg;

    // Default frame length in bytes, CRC byte included
    localparam int FRAME_BYTES_DEF = 16;

    // Highest frame byte index that result building looks at
    localparam int LAST_BYTE = 13;

    // Reset value of the device address register
    localparam logic [7:0] ADDR_RESET = 8'hB2;

    // Reply header codes
    localparam logic [7:0] STATUS_GOOD = 8'h40;
    localparam logic [7:0] OP_INFO     = 8'h01;
    localparam logic [7:0] OP_SENSOR   = 8'h05;
    localparam logic [7:0] OP_CLOCK    = 8'h09;

    // Parameter byte codes
    localparam logic [7:0] PRM_CLOCK     = 8'h01;
    localparam logic [7:0] PRM_SERIAL    = 8'h00;
    localparam logic [7:0] PRM_VERSION   = 8'h01;
    localparam logic [7:0] PRM_BUILD     = 8'h02;
    localparam logic [7:0] PRM_PROD_DATE = 8'h03;

    // Awaited-response flag positions
    localparam int NUM_FLAGS     = 6;
    localparam int FLG_CLOCK     = 0;
    localparam int FLG_SERIAL    = 1;
    localparam int FLG_VERSION   = 2;
    localparam int FLG_BUILD     = 3;
    localparam int FLG_PROD_DATE = 4;
    localparam int FLG_SENSOR    = 5;

    typedef enum logic [3:0] {
        KIND_CRC_ERR   = 4'd0,
        KIND_IGNORED   = 4'd1,
        KIND_CLOCK     = 4'd2,
        KIND_SERIAL    = 4'd3,
        KIND_VERSION   = 4'd4,
        KIND_BUILD     = 4'd5,
        KIND_PROD_DATE = 4'd6,
        KIND_SENSOR    = 4'd7,
        KIND_POLL      = 4'd8
    } t_kind;

    typedef enum logic [2:0] {
        REQ_NONE      = 3'd0,
        REQ_CLOCK     = 3'd1,
        REQ_SERIAL    = 3'd2,
        REQ_VERSION   = 3'd3,
        REQ_BUILD     = 3'd4,
        REQ_PROD_DATE = 3'd5,
        REQ_SENSOR    = 3'd6
    } t_req;

    // Frame assembler -> response matcher
    typedef struct packed {
        logic                       done;   // last byte of a frame this beat
        logic                       good;   // CRC matched
        logic [LAST_BYTE:1][7:0]    bytes;  // frame bytes 1..13, zero past the frame
    } t_frame;

    // Response matcher -> output register
    typedef struct packed {
        logic               vld;
        t_kind              kind;
        t_req               next;
        logic [63:0]        head;
        logic [15:0]        tail;
        logic               time_invalid;
        logic signed [31:0] temp;
        logic [31:0]        hum;
        logic [15:0]        press;
    } t_result;

endpackage

>>> hdl/slfr_in_if.sv
// Input channel of the frame receiver: valid/ready with command and byte.
// No dependencies.
interface slfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

>>> hdl/slfr_out_if.sv
// Result channel of the frame receiver: valid/ready with the decoded fields.
// No dependencies.
interface slfr_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         result_kind;
    logic [2:0]         next_request;
    logic [63:0]        payload_head;
    logic [15:0]        payload_tail;
    logic               time_invalid;
    logic signed [31:0] temperature_centi;
    logic [31:0]        humidity_q10;
    logic [15:0]        pressure_hpa;

    modport source (
        output valid, output result_kind, output next_request, output payload_head,
        output payload_tail, output time_invalid, output temperature_centi,
        output humidity_q10, output pressure_hpa, input ready
    );
    modport sink (
        input valid, input result_kind, input next_request, input payload_head,
        input payload_tail, input time_invalid, input temperature_centi,
        input humidity_q10, input pressure_hpa, output ready
    );
endinterface

>>> hdl/slfr_cfg_if.sv
// Configuration write channel: valid/ready carrying the device address.
// No dependencies.
interface slfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] device_address;

    modport source (output valid, output device_address, input ready);
    modport sink   (input valid, input device_address, output ready);
endinterface

>>> hdl/sensor_link_frame_receiver_unit.sv
// Top level of the sensor link frame receiver: input beat register, frame
// assembler, response matcher and result register. Depends on slfr_pkg,
// slfr_in_if, slfr_out_if, slfr_cfg_if, slfr_frame_asm and slfr_resp_match.
//
//  Port    | Dir | Beat carries
//  --------+-----+------------------------------------------------------------
//  i_in    | in  | cmd (0 byte, 1 poll tick), rx_byte
//  o_out   | out | result_kind, next_request, payload and sensor fields
//  i_cfg   | in  | device_address (always ready)
//
//  Throughput is one input beat per cycle unless the result side stalls; a
//  beat passes the input register, then one pass of assembler and matcher,
//  into the result register. Only ticks and frame-closing bytes make results.
//  o_out.ready low holds the result register; the input register, if empty,
//  still takes one more beat before i_in.ready drops. Synchronous reset clears
//  the byte count, CRC, awaited flags, both valid bits and sets the address to 0xB2.
module sensor_link_frame_receiver_unit #(
    parameter int FRAME_BYTES = slfr_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slfr_in_if.sink     i_in,
    slfr_out_if.source  o_out,
    slfr_cfg_if.sink    i_cfg
);
    import slfr_pkg::*;

    logic       r_in_vld;
    logic       r_cmd;
    logic [7:0] r_byte;
    logic [7:0] r_link_addr;
    logic       r_out_vld;
    t_result    r_out;
    logic       w_adv, w_proc;
    t_frame     w_frame;
    t_result    w_res;

    // Handshake: the pipe moves when the result register is free or drained
    assign w_adv      = !r_out_vld || o_out.ready;
    assign w_proc     = r_in_vld && w_adv;
    assign i_in.ready = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    // Device address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_addr <= ADDR_RESET;
        end else if (i_cfg.valid) begin
            r_link_addr <= i_cfg.device_address;
        end
    end

    // Input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd  <= i_in.cmd;
            r_byte <= i_in.rx_byte;
        end
    end

    slfr_frame_asm #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_asm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (w_proc),
        .i_cmd       (r_cmd),
        .i_byte      (r_byte),
        .i_link_addr (r_link_addr),
        .o_frame     (w_frame)
    );

    slfr_resp_match u_resp_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (w_proc),
        .i_cmd   (r_cmd),
        .i_frame (w_frame),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_proc && w_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_res.vld) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid             = r_out_vld;
    assign o_out.result_kind       = r_out.kind;
    assign o_out.next_request      = r_out.next;
    assign o_out.payload_head      = r_out.head;
    assign o_out.payload_tail      = r_out.tail;
    assign o_out.time_invalid      = r_out.time_invalid;
    assign o_out.temperature_centi = r_out.temp;
    assign o_out.humidity_q10      = r_out.hum;
    assign o_out.pressure_hpa      = r_out.press;

`ifndef SYNTHESIS
    // A tick beat always becomes a poll-started result asking for a clock read
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_cmd) |=> (r_out_vld && r_out.kind == KIND_POLL
                               && r_out.next == REQ_CLOCK))
        else $error("tick beat did not yield a poll result");

    // A held input beat is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> r_in_vld)
        else $error("input beat lost during stall");

    // Failed or unmatched frames never request anything or flag the time
    a_no_req_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.kind == KIND_CRC_ERR || r_out.kind == KIND_IGNORED))
        |-> (r_out.next == REQ_NONE && !r_out.time_invalid))
        else $error("rejected frame carries a request");

    // Reset leaves both pipeline registers empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_vld && !r_out_vld))
        else $error("pipeline not empty after reset");
`endif

endmodule

>>> hdl/slfr_frame_asm.sv
// Frame assembler: address hunt, byte counter, running CRC-8 and byte store.
// Depends on slfr_pkg.
module slfr_frame_asm #(
    parameter int FRAME_BYTES = slfr_pkg::FRAME_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_proc,      // registered beat is consumed this cycle
    input  logic            i_cmd,
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_link_addr,
    output slfr_pkg::t_frame o_frame
);
    import slfr_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_crc, n_crc;
    logic             w_take, w_last;
    logic [LAST_BYTE:1][7:0] w_bytes;

    // CRC-8, poly 0x07, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Byte joins a frame if one is open or it is the address
    assign w_take = i_proc && !i_cmd && ((r_count != '0) || (i_byte == i_link_addr));
    assign w_last = (r_count == CNT_LAST);

    // Counter and CRC next state
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (w_take) begin
            if (w_last) begin
                n_count = '0;
                n_crc   = '0;
            end else begin
                n_count = r_count + 1'b1;
                n_crc   = crc8_step((r_count == '0) ? 8'h00 : r_crc, i_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // Byte store: only the bytes that results use; the byte being written
    // this beat bypasses its entry so the last byte is seen right away
    for (genvar gi = 1; gi <= LAST_BYTE; gi++) begin : g_store
        if (gi < FRAME_BYTES) begin : g_keep
            logic [7:0] r_b;
            logic       w_hit;
            assign w_hit = (r_count == CNT_W'(gi));
            always_ff @(posedge i_clk) begin
                if (w_take && w_hit) begin
                    r_b <= i_byte;
                end
            end
            assign w_bytes[gi] = w_hit ? i_byte : r_b;
        end else begin : g_zero
            assign w_bytes[gi] = 8'h00;
        end
    end

    assign o_frame.done  = w_take && w_last;
    assign o_frame.good  = (r_crc == i_byte);
    assign o_frame.bytes = w_bytes;

endmodule

>>> hdl/slfr_resp_match.sv
// Response matcher: awaited-response flags and result building per beat.
// Depends on slfr_pkg.
module slfr_resp_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_proc,
    input  logic              i_cmd,
    input  slfr_pkg::t_frame  i_frame,
    output slfr_pkg::t_result o_res
);
    import slfr_pkg::*;

    logic [NUM_FLAGS-1:0] r_flags, n_flags;
    logic [7:0] w_s1, w_op, w_prm;

    assign w_s1  = i_frame.bytes[1];
    assign w_op  = i_frame.bytes[2];
    assign w_prm = i_frame.bytes[3];

    // Result and flag update; at most one match rule fires per frame
    always_comb begin
        n_flags = r_flags;
        o_res   = '0;
        o_res.kind = KIND_IGNORED;
        o_res.next = REQ_NONE;
        if (i_proc && i_cmd) begin
            n_flags[FLG_CLOCK] = 1'b1;
            o_res.vld  = 1'b1;
            o_res.kind = KIND_POLL;
            o_res.next = REQ_CLOCK;
        end else if (i_frame.done) begin
            o_res.vld  = 1'b1;
            o_res.head = {i_frame.bytes[4], i_frame.bytes[5], i_frame.bytes[6],
                          i_frame.bytes[7], i_frame.bytes[8], i_frame.bytes[9],
                          i_frame.bytes[10], i_frame.bytes[11]};
            o_res.tail = {i_frame.bytes[12], i_frame.bytes[13]};
            if (!i_frame.good) begin
                o_res.kind = KIND_CRC_ERR;
            end else if (r_flags[FLG_CLOCK] && w_s1 == STATUS_GOOD && w_op == OP_CLOCK
                         && w_prm == PRM_CLOCK) begin
                n_flags[FLG_CLOCK]  = 1'b0;
                n_flags[FLG_SERIAL] = 1'b1;
                o_res.kind = KIND_CLOCK;
                o_res.next = REQ_SERIAL;
                o_res.time_invalid = (i_frame.bytes[11] != 8'h00);
            end else if (r_flags[FLG_SERIAL] && w_op == OP_INFO && w_prm == PRM_SERIAL) begin
                n_flags[FLG_SERIAL]  = 1'b0;
                n_flags[FLG_VERSION] = 1'b1;
                o_res.kind = KIND_SERIAL;
                o_res.next = REQ_VERSION;
            end else if (r_flags[FLG_VERSION] && w_op == OP_INFO && w_prm == PRM_VERSION) begin
                n_flags[FLG_VERSION] = 1'b0;
                n_flags[FLG_BUILD]   = 1'b1;
                o_res.kind = KIND_VERSION;
                o_res.next = REQ_BUILD;
            end else if (r_flags[FLG_BUILD] && w_op == OP_INFO && w_prm == PRM_BUILD) begin
                n_flags[FLG_BUILD]     = 1'b0;
                n_flags[FLG_PROD_DATE] = 1'b1;
                o_res.kind = KIND_BUILD;
                o_res.next = REQ_PROD_DATE;
            end else if (r_flags[FLG_PROD_DATE] && w_op == OP_INFO
                         && w_prm == PRM_PROD_DATE) begin
                n_flags[FLG_PROD_DATE] = 1'b0;
                n_flags[FLG_SENSOR]    = 1'b1;
                o_res.kind = KIND_PROD_DATE;
                o_res.next = REQ_SENSOR;
            end else if (r_flags[FLG_SENSOR] && w_s1 == STATUS_GOOD && w_op == OP_SENSOR) begin
                n_flags[FLG_SENSOR] = 1'b0;
                o_res.kind  = KIND_SENSOR;
                o_res.temp  = $signed({i_frame.bytes[4], i_frame.bytes[5],
                                       i_frame.bytes[6], i_frame.bytes[7]});
                o_res.hum   = {i_frame.bytes[8], i_frame.bytes[9],
                               i_frame.bytes[10], i_frame.bytes[11]};
                o_res.press = {i_frame.bytes[12], i_frame.bytes[13]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

endmodule
